/* rtl/core/xce_pkg.sv */
// shared types and constants of the xml character escaper
// no dependencies; imported by every module of the block
package xce_pkg;

    localparam int CHAR_W         = 16;
    localparam int NUM_EXTRA_REGS = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int KIND_W         = 3;
    localparam int POS_W          = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_CHAR_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_CHAR_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_CHAR_C = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_CHAR_D = 3'd5;

    // how a queued character is written out
    localparam logic [KIND_W-1:0] KIND_PASS = 3'd0;
    localparam logic [KIND_W-1:0] KIND_APOS = 3'd1;
    localparam logic [KIND_W-1:0] KIND_QUOT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_AMP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LT   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_HEX  = 3'd5;

    // characters used by the escapes
    localparam logic [CHAR_W-1:0] CH_AMP   = 16'h0026;
    localparam logic [CHAR_W-1:0] CH_APOS  = 16'h0027;
    localparam logic [CHAR_W-1:0] CH_QUOT  = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_LT    = 16'h003C;
    localparam logic [CHAR_W-1:0] CH_HASH  = 16'h0023;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 16'h003B;
    localparam logic [CHAR_W-1:0] CH_A     = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_L     = 16'h006C;
    localparam logic [CHAR_W-1:0] CH_M     = 16'h006D;
    localparam logic [CHAR_W-1:0] CH_O     = 16'h006F;
    localparam logic [CHAR_W-1:0] CH_P     = 16'h0070;
    localparam logic [CHAR_W-1:0] CH_Q     = 16'h0071;
    localparam logic [CHAR_W-1:0] CH_S     = 16'h0073;
    localparam logic [CHAR_W-1:0] CH_T     = 16'h0074;
    localparam logic [CHAR_W-1:0] CH_U     = 16'h0075;
    localparam logic [CHAR_W-1:0] CH_X     = 16'h0078;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_HEX_A = 16'h0037;  // 'A' minus ten

    typedef struct packed {
        logic                                  escape_mode;
        logic [2:0]                            extra_count;
        logic [NUM_EXTRA_REGS-1:0][CHAR_W-1:0] extra_chars;
    } cfg_t;

    // one classified character waiting for the back end
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  len_m1;   // output characters minus one
    } entry_t;

endpackage

/* rtl/core/xce_front.sv */
// front end: accepts input characters, tracks the end of text and classifies
// each character into a queue entry; uses xce_pkg
module xce_front #(
    parameter int EXTRA_CHARS = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  xce_pkg::cfg_t    cfg,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [15:0] in_char
    input  logic             s_tlast,   // text_last
    input  logic             q_full,
    output logic             q_push,
    output xce_pkg::entry_t  q_entry
);
    import xce_pkg::*;

    localparam int MAX_EXTRA = (EXTRA_CHARS < NUM_EXTRA_REGS) ? EXTRA_CHARS : NUM_EXTRA_REGS;

    logic text_ended_reg, text_ended_next;
    logic accept, silent, extra_hit;
    logic [POS_W-1:0] hex_len_m1;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign silent   = text_ended_reg || (s_tdata == '0);

    always_comb begin
        extra_hit = 1'b0;
        for (int i = 0; i < NUM_EXTRA_REGS; i++) begin
            if ((i < MAX_EXTRA) && (cfg.extra_count > 3'(i)) &&
                (cfg.extra_chars[i] == s_tdata)) begin
                extra_hit = 1'b1;
            end
        end
    end

    // "&#x" plus digits plus ";", no leading zeros
    always_comb begin
        if (s_tdata[15:12] != 4'd0) begin
            hex_len_m1 = 3'd7;
        end else if (s_tdata[11:8] != 4'd0) begin
            hex_len_m1 = 3'd6;
        end else if (s_tdata[7:4] != 4'd0) begin
            hex_len_m1 = 3'd5;
        end else begin
            hex_len_m1 = 3'd4;
        end
    end

    always_comb begin
        q_entry.ch = s_tdata;
        if (s_tdata == CH_APOS && !cfg.escape_mode) begin
            q_entry.kind   = KIND_APOS;
            q_entry.len_m1 = 3'd5;
        end else if (s_tdata == CH_QUOT) begin
            q_entry.kind   = KIND_QUOT;
            q_entry.len_m1 = 3'd5;
        end else if (s_tdata == CH_AMP) begin
            q_entry.kind   = KIND_AMP;
            q_entry.len_m1 = 3'd4;
        end else if (s_tdata == CH_LT) begin
            q_entry.kind   = KIND_LT;
            q_entry.len_m1 = 3'd3;
        end else if (extra_hit) begin
            q_entry.kind   = KIND_HEX;
            q_entry.len_m1 = hex_len_m1;
        end else begin
            q_entry.kind   = KIND_PASS;
            q_entry.len_m1 = 3'd0;
        end
    end

    assign q_push = accept && !silent;

    always_comb begin
        text_ended_next = text_ended_reg;
        if (accept && silent) begin
            text_ended_next = !s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_ended_reg <= 1'b0;
        end else begin
            text_ended_reg <= text_ended_next;
        end
    end

endmodule

/* rtl/core/xce_queue.sv */
// short register queue between front and back end
// holds xce_pkg::entry_t items; uses xce_pkg
module xce_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  xce_pkg::entry_t  push_entry,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output xce_pkg::entry_t  head_entry
);
    import xce_pkg::*;

    entry_t                 q_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = QUEUE_PTR_W'((QUEUE_PTR_W+1)'(wr_ptr_reg) + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = QUEUE_PTR_W'((QUEUE_PTR_W+1)'(rd_ptr_reg) + 1'b1);
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !head_valid))
        else $error("queue read while empty");

endmodule

/* rtl/core/xce_back.sv */
// back end: expands the queue head into output characters, one per cycle
// unless m_ stalls, into a registered result stage; uses xce_pkg
module xce_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  xce_pkg::entry_t  head_entry,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [15:0] out_char
    output logic             m_tlast    // run_last
);
    import xce_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg;
    logic              emit, at_end;
    logic [CHAR_W-1:0] emit_char;

    function automatic logic [CHAR_W-1:0] esc_char(
        input logic [KIND_W-1:0] kind,
        input logic [POS_W-1:0]  pos,
        input logic [POS_W-1:0]  len_m1,
        input logic [CHAR_W-1:0] ch
    );
        logic [1:0]        sel;
        logic [3:0]        nib;
        logic [CHAR_W-1:0] r;
        // digit position counts down from the top nibble that is shown
        sel = 2'(len_m1 - 3'd1 - pos);
        nib = ch[{sel, 2'b00} +: 4];
        r   = ch;
        unique case (kind)
            KIND_APOS: begin
                case (pos)
                    3'd0:    r = CH_AMP;
                    3'd1:    r = CH_A;
                    3'd2:    r = CH_P;
                    3'd3:    r = CH_O;
                    3'd4:    r = CH_S;
                    default: r = CH_SEMI;
                endcase
            end
            KIND_QUOT: begin
                case (pos)
                    3'd0:    r = CH_AMP;
                    3'd1:    r = CH_Q;
                    3'd2:    r = CH_U;
                    3'd3:    r = CH_O;
                    3'd4:    r = CH_T;
                    default: r = CH_SEMI;
                endcase
            end
            KIND_AMP: begin
                case (pos)
                    3'd0:    r = CH_AMP;
                    3'd1:    r = CH_A;
                    3'd2:    r = CH_M;
                    3'd3:    r = CH_P;
                    default: r = CH_SEMI;
                endcase
            end
            KIND_LT: begin
                case (pos)
                    3'd0:    r = CH_AMP;
                    3'd1:    r = CH_L;
                    3'd2:    r = CH_T;
                    default: r = CH_SEMI;
                endcase
            end
            KIND_HEX: begin
                if (pos == 3'd0) begin
                    r = CH_AMP;
                end else if (pos == 3'd1) begin
                    r = CH_HASH;
                end else if (pos == 3'd2) begin
                    r = CH_X;
                end else if (pos == len_m1) begin
                    r = CH_SEMI;
                end else if (nib < 4'd10) begin
                    r = CH_ZERO + CHAR_W'(nib);
                end else begin
                    r = CH_HEX_A + CHAR_W'(nib);
                end
            end
            default: r = ch;
        endcase
        return r;
    endfunction

    assign emit      = head_valid && (!out_valid_reg || m_tready);
    assign at_end    = (pos_reg == head_entry.len_m1);
    assign pop       = emit && at_end;
    assign emit_char = esc_char(head_entry.kind, pos_reg, head_entry.len_m1, head_entry.ch);

    always_comb begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (emit) begin
            pos_next       = at_end ? '0 : pos_reg + 1'b1;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_char_reg <= emit_char;
            out_last_reg <= at_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    a_pos_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> (pos_reg <= head_entry.len_m1))
        else $error("output position past end of escape");

    a_last_marks_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (m_tlast == $past(at_end)))
        else $error("run_last does not match end of run");

    a_pos_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> (pos_reg == '0))
        else $error("position left nonzero with queue empty");

endmodule

/* rtl/core/xml_character_escaper_unit.sv */
// xml character escaper top level: configuration registers, front end,
// queue and back end; uses xce_pkg, xce_front, xce_queue, xce_back
//
// s_ channel: one 16-bit character a request, tlast marks the end of a text.
// m_ channel: escaped text, one character a request; tlast is high on the
// last character that one input character produced.
// cfg channel: register writes (index, data), always ready; write only while
// the block is idle.
// An accepted character is registered in the queue and then in the output
// stage before it shows on m_. A plain character gives one character, a
// fixed escape four to six, a hex reference five to eight; the back end
// writes one per cycle unless m_ stalls. Input is taken every cycle while the
// four-entry queue has room, so bursts of plain text run at one per cycle.
// A zero character and everything after it up to tlast produce nothing.
// Reset clears the registers, the end-of-text flag, the queue and the
// output stage. When m_tready is low the output holds, the queue fills and
// then s_tready drops.
module xml_character_escaper_unit #(
    parameter int EXTRA_CHARS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] in_char
    input  logic        s_tlast,     // text_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [15:0] out_char
    output logic        m_tlast,     // run_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import xce_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   q_push, q_pop, q_full, head_valid;
    entry_t push_entry, head_entry;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ESCAPE_MODE:  cfg_next.escape_mode    = cfg_data[0];
                REG_EXTRA_COUNT:  cfg_next.extra_count    = cfg_data[2:0];
                REG_EXTRA_CHAR_A: cfg_next.extra_chars[0] = cfg_data;
                REG_EXTRA_CHAR_B: cfg_next.extra_chars[1] = cfg_data;
                REG_EXTRA_CHAR_C: cfg_next.extra_chars[2] = cfg_data;
                REG_EXTRA_CHAR_D: cfg_next.extra_chars[3] = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    xce_front #(
        .EXTRA_CHARS(EXTRA_CHARS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    xce_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    xce_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

/* sim/xce_stream_checker.sv */
// stream checker for the xml character escaper: watches the cfg, s_ and m_ channels,
// predicts the escaped output of every accepted character and compares it on m_
// uses xce_pkg for register indexes and the characters of the escapes
module xce_stream_checker #(
    parameter int EXTRA_CHARS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          outstanding,
    output int          chars_out
);
    import xce_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } out_char_t;

    out_char_t         pending_chars[$];
    logic              attr_mode_off;   // 1 = element text, apostrophe passes
    logic [2:0]        extra_count;
    logic [CHAR_W-1:0] extra_chars[NUM_EXTRA_REGS];
    logic              text_done;
    int                n_fail = 0;
    int                n_out  = 0;

    initial begin
        fail_count  = 0;
        outstanding = 0;
        chars_out   = 0;
    end

    function automatic bit is_extra_char(logic [CHAR_W-1:0] c);
        int limit;
        limit = int'(extra_count);
        if (limit > EXTRA_CHARS)
            limit = EXTRA_CHARS;
        if (limit > NUM_EXTRA_REGS)
            limit = NUM_EXTRA_REGS;
        for (int i = 0; i < limit; i++)
            if (extra_chars[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    // queues the output characters that one text character turns into
    function automatic void escape_char(logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] seq[$];
        logic [3:0]        nib;
        bit                started = 1'b0;
        if (c == CH_APOS && !attr_mode_off)
            seq = '{CH_AMP, CH_A, CH_P, CH_O, CH_S, CH_SEMI};
        else if (c == CH_QUOT)
            seq = '{CH_AMP, CH_Q, CH_U, CH_O, CH_T, CH_SEMI};
        else if (c == CH_AMP)
            seq = '{CH_AMP, CH_A, CH_M, CH_P, CH_SEMI};
        else if (c == CH_LT)
            seq = '{CH_AMP, CH_L, CH_T, CH_SEMI};
        else if (is_extra_char(c)) begin
            seq = '{CH_AMP, CH_HASH, CH_X};
            // uppercase hex, leading zeros dropped
            for (int s = 12; s >= 0; s -= 4) begin
                nib = c[s +: 4];
                if (nib != 4'd0 || started || s == 0) begin
                    started = 1'b1;
                    seq.push_back(nib < 4'd10 ? CH_ZERO + CHAR_W'(nib)
                                              : CH_HEX_A + CHAR_W'(nib));
                end
            end
            seq.push_back(CH_SEMI);
        end else begin
            seq = '{c};
        end
        foreach (seq[i])
            pending_chars.push_back('{ch: seq[i], last: (i == seq.size() - 1)});
    endfunction

    always @(posedge aclk) begin
        out_char_t want;
        if (!aresetn) begin
            pending_chars.delete();
            attr_mode_off = 1'b0;
            extra_count   = '0;
            foreach (extra_chars[i])
                extra_chars[i] = '0;
            text_done = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ESCAPE_MODE:  attr_mode_off  = cfg_data[0];
                    REG_EXTRA_COUNT:  extra_count    = cfg_data[2:0];
                    REG_EXTRA_CHAR_A: extra_chars[0] = cfg_data;
                    REG_EXTRA_CHAR_B: extra_chars[1] = cfg_data;
                    REG_EXTRA_CHAR_C: extra_chars[2] = cfg_data;
                    REG_EXTRA_CHAR_D: extra_chars[3] = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                n_out++;
                if (pending_chars.size() == 0) begin
                    $error("out_char: expected nothing, got %h", m_tdata);
                    n_fail++;
                end else begin
                    want = pending_chars.pop_front();
                    if (m_tdata !== want.ch) begin
                        $error("out_char: expected %h, got %h", want.ch, m_tdata);
                        n_fail++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("run_last: expected %b, got %b", want.last, m_tlast);
                        n_fail++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                // a zero ends the text; silence lasts through the request marked last
                if (text_done || s_tdata == '0)
                    text_done = !s_tlast;
                else
                    escape_char(s_tdata);
            end
        end
        fail_count  <= n_fail;
        chars_out   <= n_out;
        outstanding <= pending_chars.size();
    end

endmodule

/* sim/testbench.sv */
// top of the xml character escaper testbench: clock, reset, stimulus and verdict
// depends on xce_pkg, xml_character_escaper_unit and xce_stream_checker
module testbench;
    import xce_pkg::*;

    localparam int              CYCLE_LIMIT  = 200000;
    localparam int              LONG_HOLD    = 80;
    localparam logic [2:0]      REG_SPARE_LO = 3'd6;
    localparam logic [2:0]      REG_SPARE_HI = 3'd7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    int          fail_count;
    int          outstanding;
    int          chars_out;

    logic        rx_idle_on    = 1'b1;
    logic        pressure_go   = 1'b0;
    logic        pressure_done = 1'b0;
    int          hold_left     = 0;
    int          rx_gap        = 0;
    int          cycles        = 0;
    bit          tx_idle_on    = 1'b1;
    int          chars_in      = 0;
    int          settings      = 0;
    logic [15:0] extra_pool[NUM_EXTRA_REGS];

    xml_character_escaper_unit dut (.*);
    xce_stream_checker chk (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result side: random stall bursts plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
        end else if (pressure_go && !pressure_done) begin
            pressure_done <= 1'b1;
            hold_left     <= LONG_HOLD;
            m_tready      <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= (rx_gap == 1);
        end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            rx_gap   <= $urandom_range(1, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic cfg_stop();
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic send_char(input logic [15:0] ch, input logic last);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        chars_in++;
    endtask

    // stop offering, then let every expected character come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_special();
        case ($urandom_range(0, 3))
            0: return CH_APOS;
            1: return CH_QUOT;
            2: return CH_AMP;
            default: return CH_LT;
        endcase
    endfunction

    function automatic logic [15:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 16'($urandom_range(1, 65535));
        else if (r < 45)
            return 16'($urandom_range(16'h20, 16'h7E));
        else if (r < 65)
            return pick_special();
        else if (r < 85)
            return extra_pool[$urandom_range(0, NUM_EXTRA_REGS - 1)];
        else if (r < 92)
            return 16'h0000;
        else
            return 16'($urandom_range(1, 255));
    endfunction

    function automatic logic [15:0] pick_extra();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 16'($urandom_range(0, 65535));
        else if (r < 60)
            return 16'($urandom_range(1, 15));
        else if (r < 75)
            return pick_special();
        else if (r < 85)
            return 16'hFFFF;
        else if (r < 90)
            return 16'h0000;
        else
            return 16'($urandom_range(16'h20, 16'h7E));
    endfunction

    task automatic program_random(input int phase);
        logic [2:0]  count;
        logic [15:0] mode_word;
        mode_word = 16'($urandom_range(0, 65535));
        if (phase == 0)
            mode_word = 16'h0000;
        count = 3'($urandom_range(0, 7));
        if (phase == 0)
            count = 3'd0;
        else if (phase == 1 || phase == 2)
            count = 3'd4;
        write_reg(REG_ESCAPE_MODE, mode_word);
        write_reg(REG_EXTRA_COUNT, {13'($urandom_range(0, 8191)), count});
        foreach (extra_pool[i]) begin
            extra_pool[i] = pick_extra();
            write_reg(REG_EXTRA_CHAR_A + 3'(i), extra_pool[i]);
        end
        if ($urandom_range(0, 1) == 1)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                      16'($urandom_range(0, 65535)));
        cfg_stop();
    endtask

    // texts of random length; now and then a text is cut short by an early last
    task automatic run_texts(input int target);
        int          live;
        int          len;
        bit          dead;
        logic [15:0] ch;
        logic        last;
        live = 0;
        while (live < target) begin
            len  = $urandom_range(1, 10);
            dead = 1'b0;
            for (int i = 0; i < len; i++) begin
                ch   = pick_char();
                last = (i == len - 1) || ($urandom_range(0, 24) == 0);
                if (ch == '0)
                    dead = 1'b1;
                if (!dead)
                    live++;
                send_char(ch, last);
                if (last)
                    dead = 1'b0;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // attribute mode, all four extras, one of them shadowed by a fixed escape
        write_reg(REG_ESCAPE_MODE, 16'h0000);
        write_reg(REG_EXTRA_COUNT, 16'h0004);
        write_reg(REG_EXTRA_CHAR_A, 16'hFFFF);
        write_reg(REG_EXTRA_CHAR_B, 16'h0001);
        write_reg(REG_EXTRA_CHAR_C, CH_AMP);
        write_reg(REG_EXTRA_CHAR_D, 16'h0ABC);
        cfg_stop();
        send_char(16'h0041, 1'b0);
        send_char(CH_APOS, 1'b0);
        send_char(CH_QUOT, 1'b0);
        send_char(CH_AMP, 1'b0);
        send_char(CH_LT, 1'b0);
        send_char(16'hFFFF, 1'b0);
        send_char(16'h0001, 1'b0);
        send_char(16'h0ABC, 1'b0);
        send_char(16'hFFFE, 1'b1);
        // terminator mid text, then silence through the last request
        send_char(16'h0000, 1'b0);
        send_char(16'h0041, 1'b0);
        send_char(CH_AMP, 1'b1);
        send_char(16'h0000, 1'b1);
        send_char(16'h7FFF, 1'b1);
        send_char(16'h8000, 1'b0);
        drain();

        // element text, count above the register set, a zero extra, spare indexes
        write_reg(REG_ESCAPE_MODE, 16'hFFFF);
        write_reg(REG_EXTRA_COUNT, 16'hFFFF);
        write_reg(REG_EXTRA_CHAR_A, 16'h00AB);
        write_reg(REG_EXTRA_CHAR_B, 16'h1000);
        write_reg(REG_EXTRA_CHAR_D, 16'h0000);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        cfg_stop();
        send_char(CH_APOS, 1'b0);
        send_char(CH_QUOT, 1'b0);
        send_char(16'h00AB, 1'b0);
        send_char(16'h1000, 1'b0);
        send_char(16'h0005, 1'b0);
        send_char(16'h0000, 1'b1);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            program_random(phase);
            tx_idle_on = (phase != 2 && phase != 5);
            rx_idle_on <= (phase != 5);
            // hold the result side while requests keep coming
            if (phase == 2)
                pressure_go <= 1'b1;
            run_texts(38);
            drain();
        end

        $display("run covered %0d input characters and %0d output characters", chars_in,
                 chars_out);
        $display("across %0d register settings, both escape modes and one long output stall",
                 settings);
        if (fail_count == 0 && outstanding == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
